>>> hw/rtl/rhsl_pkg.sv
`timescale 1ns / 1ps

package rhsl_pkg;

  // Field widths of the pixel and of the result.
  localparam int CHAN_W = 8;
  localparam int LUM_W  = 9;
  localparam int FRAC_W = 16;
  localparam int SAT_W  = FRAC_W + 1;
  localparam int HUE_W  = FRAC_W + 2;

  // Both quotients are below 2^17, so each divider resolves 17 bits.
  localparam int DIV_STEPS = FRAC_W + 1;

  // Divisor widths: max channel for saturation, five times the span for hue.
  localparam int DEN_S_W = CHAN_W;
  localparam int DEN_H_W = CHAN_W + 3;

  // Hue sector codes.
  typedef enum logic [1:0] {
    SEC_RED   = 2'd0,
    SEC_GREEN = 2'd1,
    SEC_BLUE  = 2'd2
  } sector_t;

  // Everything one item carries through the divider stages.
  typedef struct packed {
    logic [DEN_S_W-1:0] rem_s;
    logic [DEN_S_W-1:0] den_s;
    logic               low_s;
    logic [SAT_W-1:0]   quo_s;
    logic [DEN_H_W-1:0] rem_h;
    logic [DEN_H_W-1:0] den_h;
    logic               low_h;
    logic [SAT_W-1:0]   quo_h;
    logic               neg;
    logic               grey;
    logic [LUM_W-1:0]   lum;
  } div_stage_t;

endpackage

>>> hw/rtl/rgb_to_hue_sat_lum.sv
`timescale 1ns / 1ps

// Pipeline: two front-end stages, 17 divider stages resolving one quotient bit
// each for saturation and hue, and one output stage.
// Throughput: one item per clock; busy is always low and the receiver cannot stall.
// Reset (rst_n low, synchronous) clears every stage valid bit, so no result
// appears until items enter after reset.
module rgb_to_hue_sat_lum import rhsl_pkg::*; (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    start,
  output logic                    busy,
  input  logic [CHAN_W-1:0]       in_red,
  input  logic [CHAN_W-1:0]       in_green,
  input  logic [CHAN_W-1:0]       in_blue,
  output logic                    out_valid,
  output logic [LUM_W-1:0]        out_lum_sum,
  output logic [SAT_W-1:0]        out_sat_q16,
  output logic signed [HUE_W-1:0] out_hue_q16,
  output logic                    out_is_grey
);

  localparam int NUM_W = DEN_H_W + 1;

  // The pipeline never holds an item back.
  assign busy = 1'b0;

  // First front-end stage: max, min, span, sector and the channel difference.
  logic [CHAN_W-1:0]       hi_c;
  logic [CHAN_W-1:0]       lo_c;
  logic [CHAN_W-1:0]       span_c;
  sector_t                 sec_c;
  logic signed [CHAN_W:0]  diff_c;

  always_comb begin
    hi_c = in_red;
    if (in_green > hi_c) hi_c = in_green;
    if (in_blue > hi_c) hi_c = in_blue;
    lo_c = in_red;
    if (in_green < lo_c) lo_c = in_green;
    if (in_blue < lo_c) lo_c = in_blue;
    span_c = hi_c - lo_c;

    // Red wins ties over green, green over blue.
    if (hi_c == in_red) begin
      sec_c = SEC_RED;
    end else if (hi_c == in_green) begin
      sec_c = SEC_GREEN;
    end else begin
      sec_c = SEC_BLUE;
    end

    unique case (sec_c)
      SEC_RED: begin
        diff_c = $signed({1'b0, in_green}) - $signed({1'b0, in_blue});
      end
      SEC_GREEN: begin
        diff_c = $signed({1'b0, in_blue}) - $signed({1'b0, in_red});
      end
      SEC_BLUE: begin
        diff_c = $signed({1'b0, in_red}) - $signed({1'b0, in_green});
      end
      default: begin
        diff_c = '0;
      end
    endcase
  end

  logic                   pre_vld_r;
  logic [CHAN_W-1:0]      pre_hi_r;
  logic [CHAN_W-1:0]      pre_span_r;
  sector_t                pre_sec_r;
  logic signed [CHAN_W:0] pre_diff_r;
  logic                   pre_grey_r;
  logic [LUM_W-1:0]       pre_lum_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pre_vld_r <= 1'b0;
    end else begin
      pre_vld_r <= start;
    end
    pre_hi_r   <= hi_c;
    pre_span_r <= span_c;
    pre_sec_r  <= sec_c;
    pre_diff_r <= diff_c;
    pre_grey_r <= (hi_c == lo_c);
    pre_lum_r  <= {1'b0, hi_c} + {1'b0, lo_c};
  end

  // Second front-end stage: the hue numerator, its magnitude and both divisors.
  logic [CHAN_W+1:0]       base_c;
  logic signed [NUM_W-1:0] num_c;
  logic [NUM_W-1:0]        mag_c;
  div_stage_t              front_nxt;

  always_comb begin
    unique case (pre_sec_r)
      SEC_RED: begin
        base_c = '0;
      end
      SEC_GREEN: begin
        base_c = {1'b0, pre_span_r, 1'b0};
      end
      SEC_BLUE: begin
        base_c = {pre_span_r, 2'b00};
      end
      default: begin
        base_c = '0;
      end
    endcase

    num_c = $signed({2'b00, base_c}) +
            $signed({{(NUM_W-CHAN_W-1){pre_diff_r[CHAN_W]}}, pre_diff_r});
    mag_c = num_c[NUM_W-1] ? NUM_W'(-num_c) : NUM_W'(num_c);

    // The first remainder takes all numerator bits above the 17 quotient
    // positions; the lowest non-zero numerator bit enters at the first step.
    front_nxt.rem_s = {1'b0, pre_span_r[CHAN_W-1:1]};
    front_nxt.den_s = pre_hi_r;
    front_nxt.low_s = pre_span_r[0];
    front_nxt.quo_s = '0;
    front_nxt.rem_h = mag_c[DEN_H_W:1];
    front_nxt.den_h = {3'b000, pre_span_r} + {1'b0, pre_span_r, 2'b00};
    front_nxt.low_h = mag_c[0];
    front_nxt.quo_h = '0;
    front_nxt.neg   = num_c[NUM_W-1];
    front_nxt.grey  = pre_grey_r;
    front_nxt.lum   = pre_lum_r;
  end

  // Stage registers: entry 0 follows the front end, entry k follows divider step k.
  div_stage_t st_r  [DIV_STEPS+1];
  logic       vld_r [DIV_STEPS+1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r[0] <= 1'b0;
    end else begin
      vld_r[0] <= pre_vld_r;
    end
    st_r[0] <= front_nxt;
  end

  // Restoring division, one quotient bit per stage for both dividers.
  for (genvar g = 0; g < DIV_STEPS; g++) begin : g_div
    logic [DEN_S_W:0] sh_s;
    logic [DEN_H_W:0] sh_h;
    logic             bit_s;
    logic             bit_h;
    div_stage_t       stage_nxt;

    always_comb begin
      stage_nxt = st_r[g];
      sh_s = {st_r[g].rem_s, (g == 0) ? st_r[g].low_s : 1'b0};
      sh_h = {st_r[g].rem_h, (g == 0) ? st_r[g].low_h : 1'b0};
      bit_s = (sh_s >= {1'b0, st_r[g].den_s});
      bit_h = (sh_h >= {1'b0, st_r[g].den_h});
      stage_nxt.rem_s = bit_s ? DEN_S_W'(sh_s - {1'b0, st_r[g].den_s}) : sh_s[DEN_S_W-1:0];
      stage_nxt.rem_h = bit_h ? DEN_H_W'(sh_h - {1'b0, st_r[g].den_h}) : sh_h[DEN_H_W-1:0];
      stage_nxt.quo_s = {st_r[g].quo_s[SAT_W-2:0], bit_s};
      stage_nxt.quo_h = {st_r[g].quo_h[SAT_W-2:0], bit_h};
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[g+1] <= 1'b0;
      end else begin
        vld_r[g+1] <= vld_r[g];
      end
      st_r[g+1] <= stage_nxt;
    end
  end

  // Output stage: sign the hue and clear both fractions for grey pixels.
  logic [HUE_W-1:0] hue_mag;
  logic [HUE_W-1:0] hue_nxt;
  logic [SAT_W-1:0] sat_nxt;

  always_comb begin
    hue_mag = {1'b0, st_r[DIV_STEPS].quo_h};
    if (st_r[DIV_STEPS].grey) begin
      hue_nxt = '0;
      sat_nxt = '0;
    end else begin
      hue_nxt = st_r[DIV_STEPS].neg ? HUE_W'(-hue_mag) : hue_mag;
      sat_nxt = st_r[DIV_STEPS].quo_s;
    end
  end

  logic             out_valid_r;
  logic [LUM_W-1:0] lum_r;
  logic [SAT_W-1:0] sat_r;
  logic [HUE_W-1:0] hue_r;
  logic             grey_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= vld_r[DIV_STEPS];
    end
    lum_r  <= st_r[DIV_STEPS].lum;
    sat_r  <= sat_nxt;
    hue_r  <= hue_nxt;
    grey_r <= st_r[DIV_STEPS].grey;
  end

  assign out_valid   = out_valid_r;
  assign out_lum_sum = lum_r;
  assign out_sat_q16 = sat_r;
  assign out_hue_q16 = $signed(hue_r);
  assign out_is_grey = grey_r;

endmodule

>>> tb/rgb_to_hue_sat_lum_tb.sv
`timescale 1ns / 1ps

module rgb_to_hue_sat_lum_tb;
  import rhsl_pkg::*;

  localparam int PIXEL_COUNT = 550;
  localparam int DRAIN_CYCLES = 40;
  localparam int CYCLE_LIMIT = 40000;

  // One result item as the block presents it.
  typedef struct packed {
    logic [LUM_W-1:0]        lum_sum;
    logic [SAT_W-1:0]        sat_q16;
    logic signed [HUE_W-1:0] hue_q16;
    logic                    is_grey;
  } hsl_t;

  // Works out the hue, saturation and luminosity of each accepted pixel and
  // compares the block's results with them in order.
  class hsl_scoreboard;
    hsl_t pending_hsl[$];
    int   mismatches;
    int   reported;

    function automatic hsl_t predict_hsl(logic [CHAN_W-1:0] r, logic [CHAN_W-1:0] g,
                                         logic [CHAN_W-1:0] b);
      hsl_t    res;
      int      hi;
      int      lo;
      int      span;
      int      base;
      int      diff;
      longint  num;
      longint  quo;
      sector_t sec;
      hi = r;
      lo = r;
      if (g > hi) hi = g;
      if (b > hi) hi = b;
      if (g < lo) lo = g;
      if (b < lo) lo = b;
      res.lum_sum = LUM_W'(hi + lo);
      res.sat_q16 = '0;
      res.hue_q16 = '0;
      res.is_grey = 1'b0;
      if (hi == lo) begin
        res.is_grey = 1'b1;
      end else begin
        span = hi - lo;
        res.sat_q16 = SAT_W'((span * 65536) / hi);
        // Ties go to red first, then green.
        if (hi == r) sec = SEC_RED;
        else if (hi == g) sec = SEC_GREEN;
        else sec = SEC_BLUE;
        case (sec)
          SEC_RED: begin
            base = 0;
            diff = int'(g) - int'(b);
          end
          SEC_GREEN: begin
            base = 2;
            diff = int'(b) - int'(r);
          end
          default: begin
            base = 4;
            diff = int'(r) - int'(g);
          end
        endcase
        // Signed division truncates toward zero, so a negative hue stays negative.
        num = longint'(base * span + diff) * 64'sd65536;
        quo = num / longint'(5 * span);
        res.hue_q16 = HUE_W'(quo);
      end
      return res;
    endfunction

    function void note_pixel(logic [CHAN_W-1:0] r, logic [CHAN_W-1:0] g,
                             logic [CHAN_W-1:0] b);
      pending_hsl.push_back(predict_hsl(r, g, b));
    endfunction

    function void check_result(hsl_t got);
      hsl_t want;
      if (pending_hsl.size() == 0) begin
        mismatches++;
        if (reported < 10) begin
          reported++;
          $display("unexpected result item: lum %0d sat %0d hue %0d grey %0d",
                   got.lum_sum, got.sat_q16, $signed(got.hue_q16), got.is_grey);
        end
        return;
      end
      want = pending_hsl.pop_front();
      if (got.lum_sum !== want.lum_sum || got.sat_q16 !== want.sat_q16 ||
          got.hue_q16 !== want.hue_q16 || got.is_grey !== want.is_grey) begin
        mismatches++;
        if (reported < 10) begin
          reported++;
          $display("mismatch: expected lum %0d sat %0d hue %0d grey %0d, got lum %0d sat %0d hue %0d grey %0d",
                   want.lum_sum, want.sat_q16, $signed(want.hue_q16), want.is_grey,
                   got.lum_sum, got.sat_q16, $signed(got.hue_q16), got.is_grey);
        end
      end
    endfunction
  endclass

  logic              clk;
  logic              rst_n;
  logic              start;
  logic              busy;
  logic [CHAN_W-1:0] in_red;
  logic [CHAN_W-1:0] in_green;
  logic [CHAN_W-1:0] in_blue;
  logic              out_valid;
  logic [LUM_W-1:0]  out_lum_sum;
  logic [SAT_W-1:0]  out_sat_q16;
  logic signed [HUE_W-1:0] out_hue_q16;
  logic              out_is_grey;

  hsl_scoreboard sb;
  int            cycles;
  int            burst_left;

  rgb_to_hue_sat_lum uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .in_red     (in_red),
    .in_green   (in_green),
    .in_blue    (in_blue),
    .out_valid  (out_valid),
    .out_lum_sum(out_lum_sum),
    .out_sat_q16(out_sat_q16),
    .out_hue_q16(out_hue_q16),
    .out_is_grey(out_is_grey)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Note each accepted item and check each result on the rising edge.
  always @(posedge clk) begin
    if (rst_n && start === 1'b1 && busy === 1'b0) begin
      sb.note_pixel(in_red, in_green, in_blue);
    end
    if (rst_n && out_valid !== 1'b0) begin
      sb.check_result('{out_lum_sum, out_sat_q16, out_hue_q16, out_is_grey});
    end
  end

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("rgb_to_hue_sat_lum_tb: done, errors");
      $finish;
    end
  end

  // Present one pixel and hold it until the block takes it.
  task automatic send_pixel(logic [CHAN_W-1:0] r, logic [CHAN_W-1:0] g,
                            logic [CHAN_W-1:0] b);
    @(negedge clk);
    start    <= 1'b1;
    in_red   <= r;
    in_green <= g;
    in_blue  <= b;
    do @(posedge clk); while (busy !== 1'b0);
  endtask

  task automatic idle_cycles(int n);
    repeat (n) begin
      @(negedge clk);
      start <= 1'b0;
    end
  endtask

  // Sends pixels in bursts of random length with random gaps between them.
  task automatic send_bursty(logic [CHAN_W-1:0] r, logic [CHAN_W-1:0] g,
                             logic [CHAN_W-1:0] b);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 16);
      if ($urandom_range(0, 3) != 0) idle_cycles($urandom_range(1, 6));
    end
    burst_left--;
    send_pixel(r, g, b);
  endtask

  initial begin
    logic [CHAN_W-1:0] r;
    logic [CHAN_W-1:0] g;
    logic [CHAN_W-1:0] b;
    int                mode;
    int                drain;
    sb         = new;
    cycles     = 0;
    burst_left = 0;
    rst_n      = 1'b0;
    start      = 1'b0;
    in_red     = '0;
    in_green   = '0;
    in_blue    = '0;
    repeat (8) @(negedge clk);
    rst_n <= 1'b1;

    // Directed items: extremes, grey pixels, ties for the maximum and
    // negative hue in the red sector.
    send_pixel(8'd0, 8'd0, 8'd0);
    send_pixel(8'd255, 8'd255, 8'd255);
    send_pixel(8'd128, 8'd128, 8'd128);
    send_pixel(8'd1, 8'd1, 8'd1);
    send_pixel(8'd255, 8'd0, 8'd0);
    send_pixel(8'd0, 8'd255, 8'd0);
    send_pixel(8'd0, 8'd0, 8'd255);
    send_pixel(8'd255, 8'd255, 8'd0);
    send_pixel(8'd0, 8'd255, 8'd255);
    send_pixel(8'd255, 8'd0, 8'd255);
    send_pixel(8'd200, 8'd10, 8'd200);
    send_pixel(8'd255, 8'd0, 8'd1);
    send_pixel(8'd255, 8'd254, 8'd0);
    send_pixel(8'd1, 8'd0, 8'd0);
    send_pixel(8'd0, 8'd1, 8'd0);
    send_pixel(8'd0, 8'd0, 8'd1);
    send_pixel(8'd1, 8'd0, 8'd255);
    send_pixel(8'd0, 8'd255, 8'd254);
    send_pixel(8'd255, 8'd254, 8'd254);
    send_pixel(8'd170, 8'd85, 8'd0);
    send_pixel(8'd85, 8'd170, 8'd255);
    send_pixel(8'd254, 8'd255, 8'd255);
    idle_cycles(3);

    // Random pixels: mostly uniform, with grey pixels, ties and narrow spans
    // mixed in.
    repeat (PIXEL_COUNT) begin
      mode = $urandom_range(0, 9);
      r = 8'($urandom_range(0, 255));
      g = 8'($urandom_range(0, 255));
      b = 8'($urandom_range(0, 255));
      case (mode)
        0: begin
          g = r;
          b = r;
        end
        1: g = r;
        2: b = g;
        3: b = r;
        4: begin
          g = 8'(int'(r) + $urandom_range(0, 2) - 1);
          b = 8'(int'(r) + $urandom_range(0, 2) - 1);
        end
        default: ;
      endcase
      send_bursty(r, g, b);
    end
    idle_cycles(1);

    // Let the pipeline empty, then allow for its latency.
    while (sb.pending_hsl.size() != 0) @(posedge clk);
    drain = DRAIN_CYCLES;
    repeat (drain) @(posedge clk);

    if (sb.mismatches == 0 && sb.pending_hsl.size() == 0) begin
      $display("rgb_to_hue_sat_lum_tb: done, clean");
    end else begin
      $display("rgb_to_hue_sat_lum_tb: done, errors");
    end
    $finish;
  end

endmodule
